[hw/rtl/rdtc_pkg.sv]
// ----------------------------------------------------------------------------
// rdtc_pkg - shared types, codes and helpers for the RTC date-time checker
// Payload structs, status and register codes, BCD and calendar helpers.
// ----------------------------------------------------------------------------
package rdtc_pkg;

   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCESS_ENABLE      = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BCD_PATH_SUPPORTED = 1'd1;

   localparam logic [1:0] STATUS_OK              = 2'd0;
   localparam logic [1:0] STATUS_ACCESS_DISABLED = 2'd1;
   localparam logic [1:0] STATUS_INVALID         = 2'd2;
   localparam logic [1:0] STATUS_BCD_UNSUPPORTED = 2'd3;

   localparam logic OP_BINARY = 1'b0;
   localparam logic OP_BCD    = 1'b1;

   localparam logic [15:0] YEAR_MIN      = 16'd2000;
   localparam logic [15:0] YEAR_MAX      = 16'd2099;
   localparam logic [7:0]  YEAR_BCD_HIGH = 8'h20;
   localparam logic [7:0]  MONTH_MAX     = 8'd12;
   localparam logic [7:0]  HOUR_MAX      = 8'd23;
   localparam logic [7:0]  MINUTE_MAX    = 8'd59;
   localparam logic [7:0]  SECOND_MAX    = 8'd59;
   localparam logic [7:0]  CSEC_MAX      = 8'd99;
   localparam logic [4:0]  FEB_LEAP_DAYS = 5'd29;

   typedef struct packed {
      logic        operation;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic [7:0]  centisecond;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] rtc_time_word;
      logic [31:0] rtc_date_word;
   } rsp_type;

   function automatic logic bcd_ok(input logic [7:0] v);
      return (v[7:4] <= 4'd9) && (v[3:0] <= 4'd9);
   endfunction

   // hi * 10 + lo; stays within 8 bits even for bad digits
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
      logic [7:0] hi;
      hi = {4'd0, v[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
   endfunction

   // valid for v below 100; tens via reciprocal 205 / 2048
   function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {8'd0, v} * 15'd205;
      tens = prod[14:11];
      ones = v - 7'({3'd0, tens} * 7'd10);
      return {tens, ones[3:0]};
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] d;
      case (month)
         4'd1:    d = 5'd31;
         4'd2:    d = 5'd28;
         4'd3:    d = 5'd31;
         4'd4:    d = 5'd30;
         4'd5:    d = 5'd31;
         4'd6:    d = 5'd30;
         4'd7:    d = 5'd31;
         4'd8:    d = 5'd31;
         4'd9:    d = 5'd30;
         4'd10:   d = 5'd31;
         4'd11:   d = 5'd30;
         4'd12:   d = 5'd31;
         default: d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

[hw/rtl/rdtc_check.sv]
// ----------------------------------------------------------------------------
// rdtc_check - date-time range check and BCD pack
// Combinational: decodes BCD fields, checks calendar and clock ranges,
// forms status and the two RTC words.
// ----------------------------------------------------------------------------
module rdtc_check (
   input  rdtc_pkg::req_type req,
   input  logic              access_enable,
   input  logic              bcd_path_supported,
   output rdtc_pkg::rsp_type rsp
);

   logic       is_bcd;
   logic       digits_ok;
   logic       year_ok;
   logic [6:0] yy;
   logic [7:0] mon_v, day_v, hr_v, mn_v, sc_v, cs_v;
   logic [4:0] dim;
   logic       leap;
   logic       fields_ok;

   always_comb begin
      is_bcd = (req.operation == rdtc_pkg::OP_BCD);

      digits_ok = rdtc_pkg::bcd_ok(req.year[15:8]) && rdtc_pkg::bcd_ok(req.year[7:0]) &&
                  rdtc_pkg::bcd_ok(req.month) && rdtc_pkg::bcd_ok(req.day) &&
                  rdtc_pkg::bcd_ok(req.hour) && rdtc_pkg::bcd_ok(req.minute) &&
                  rdtc_pkg::bcd_ok(req.second) && rdtc_pkg::bcd_ok(req.centisecond);

      // year reduced to its offset from 2000 on both paths
      if (is_bcd) begin
         year_ok = (req.year[15:8] == rdtc_pkg::YEAR_BCD_HIGH);
         yy      = 7'(rdtc_pkg::bcd_to_bin(req.year[7:0]));
         mon_v   = rdtc_pkg::bcd_to_bin(req.month);
         day_v   = rdtc_pkg::bcd_to_bin(req.day);
         hr_v    = rdtc_pkg::bcd_to_bin(req.hour);
         mn_v    = rdtc_pkg::bcd_to_bin(req.minute);
         sc_v    = rdtc_pkg::bcd_to_bin(req.second);
         cs_v    = rdtc_pkg::bcd_to_bin(req.centisecond);
      end else begin
         year_ok = (req.year >= rdtc_pkg::YEAR_MIN) && (req.year <= rdtc_pkg::YEAR_MAX);
         yy      = 7'(req.year - rdtc_pkg::YEAR_MIN);
         mon_v   = req.month;
         day_v   = req.day;
         hr_v    = req.hour;
         mn_v    = req.minute;
         sc_v    = req.second;
         cs_v    = req.centisecond;
      end

      // 2000 is a leap year, so within 2000-2099 only the offset mod 4 matters
      leap = (yy[1:0] == 2'd0);
      dim  = rdtc_pkg::month_days(mon_v[3:0]);
      if (mon_v == 8'd2 && leap) begin
         dim = rdtc_pkg::FEB_LEAP_DAYS;
      end

      fields_ok = (!is_bcd || digits_ok) && year_ok &&
                  (mon_v != 8'd0) && (mon_v <= rdtc_pkg::MONTH_MAX) &&
                  (day_v != 8'd0) && (day_v <= {3'd0, dim}) &&
                  (hr_v <= rdtc_pkg::HOUR_MAX) && (mn_v <= rdtc_pkg::MINUTE_MAX) &&
                  (sc_v <= rdtc_pkg::SECOND_MAX) && (cs_v <= rdtc_pkg::CSEC_MAX);

      rsp = '0;
      if (!access_enable) begin
         rsp.status = rdtc_pkg::STATUS_ACCESS_DISABLED;
      end else if (!fields_ok) begin
         rsp.status = rdtc_pkg::STATUS_INVALID;
      end else if (is_bcd && !bcd_path_supported) begin
         rsp.status = rdtc_pkg::STATUS_BCD_UNSUPPORTED;
      end else begin
         rsp.status        = rdtc_pkg::STATUS_OK;
         rsp.rtc_time_word = {rdtc_pkg::bin_to_bcd(hr_v[6:0]),
                              rdtc_pkg::bin_to_bcd(mn_v[6:0]),
                              rdtc_pkg::bin_to_bcd(sc_v[6:0]),
                              rdtc_pkg::bin_to_bcd(cs_v[6:0])};
         rsp.rtc_date_word = {rdtc_pkg::YEAR_BCD_HIGH,
                              rdtc_pkg::bin_to_bcd(yy),
                              rdtc_pkg::bin_to_bcd(mon_v[6:0]),
                              rdtc_pkg::bin_to_bcd(day_v[6:0])};
      end
   end

endmodule

[hw/rtl/rtc_datetime_check_and_pack.sv]
// ----------------------------------------------------------------------------
// rtc_datetime_check_and_pack - RTC date-time validation and BCD packing
// Input register, check/pack logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one date-time item per transfer (req_valid/req_ready, req_data),
//           fields binary or packed BCD as chosen by req_data.operation.
//   rsp_* : one result per item (rsp_valid/rsp_ready, rsp_data): status and
//           the two BCD RTC words, zero unless status is ok.
//   csr_* : register writes (csr_index, csr_wdata); csr_ready is always high.
//           Write only while no item is in flight.
// Path: an accepted item is held in the input register, then its result in
// the result register, which drives rsp_valid and rsp_data. Throughput: one
// item per cycle while rsp_ready is high, set by the single check stage
// between the two registers.
// Stall: while rsp_ready is low the result register holds; one more item
// waits in the input register, after which req_ready drops. Items are never
// dropped or reordered.
// Reset: both pipeline stages empty, access_enable and bcd_path_supported 1.
// ----------------------------------------------------------------------------
module rtc_datetime_check_and_pack (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  rdtc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output rdtc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rdtc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic                                   csr_wdata
);

   logic              s1_valid_ff, s1_valid_in;
   rdtc_pkg::req_type s1_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rdtc_pkg::rsp_type rsp_data_ff;
   rdtc_pkg::rsp_type chk_rsp;
   logic              access_enable_ff;
   logic              bcd_supported_ff;
   logic              s2_take;
   logic              s1_advance;
   logic              req_xfer;

   assign s2_take    = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && s2_take;
   assign req_ready  = !s1_valid_ff || s2_take;
   assign req_xfer   = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign s1_valid_in  = req_xfer || (s1_valid_ff && !s2_take);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   rdtc_check u_check (
      .req                (s1_data_ff),
      .access_enable      (access_enable_ff),
      .bcd_path_supported (bcd_supported_ff),
      .rsp                (chk_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         access_enable_ff <= 1'b1;
         bcd_supported_ff <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rdtc_pkg::CSR_ACCESS_ENABLE:      access_enable_ff <= csr_wdata;
               rdtc_pkg::CSR_BCD_PATH_SUPPORTED: bcd_supported_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_data_ff <= req_data;
      end
      if (s1_advance) begin
         rsp_data_ff <= chk_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_refusal_zero_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != rdtc_pkg::STATUS_OK) |->
      (rsp_data.rtc_time_word == 32'd0 && rsp_data.rtc_date_word == 32'd0))
      else $error("refused result carries nonzero RTC words");

   a_ok_century: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == rdtc_pkg::STATUS_OK) |->
      (rsp_data.rtc_date_word[31:24] == rdtc_pkg::YEAR_BCD_HIGH))
      else $error("accepted date outside 20xx");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_valid_ff)
      else $error("accepted item lost before check stage");

   a_csr_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (access_enable_ff && bcd_supported_ff))
      else $error("config registers not at reset value");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for rtc_datetime_check_and_pack
// Directed vectors then random date-time items on both coding paths, under
// changing register settings and random stalls on both channels. Each result
// is checked field by field against typed values or a calendar/BCD predictor.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_COUNT    = 13;
   localparam int PHASE_ITEMS    = 120;
   localparam int unsigned DIGIT_ERROR = 32'hFFFF_FFFF;

   typedef enum int {
      F_YEAR, F_MONTH, F_DAY, F_HOUR, F_MINUTE, F_SECOND, F_CSEC
   } field_sel_type;

   typedef struct {
      bit                acc;
      bit                bsup;
      rdtc_pkg::req_type item;
      bit                typed;
      rdtc_pkg::rsp_type exp;
   } vector_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rdtc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rdtc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [rdtc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = rdtc_pkg::CSR_ACCESS_ENABLE;
   logic              csr_wdata = 1'b0;

   // typed expectation travels alongside the item it belongs to
   bit                req_exp_typed = 1'b0;
   rdtc_pkg::rsp_type req_exp_val = '0;

   rdtc_pkg::rsp_type rtc_words_due[$];
   vector_row_type    vectors[$];
   int        items_accepted = 0;
   int        results_seen = 0;
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   int        rx_hold = 0;
   bit        no_idle = 1'b0;
   bit        cfg_acc = 1'b1;
   bit        cfg_bsup = 1'b1;
   bit        mirror_acc = 1'b1;
   bit        mirror_bsup = 1'b1;

   rtc_datetime_check_and_pack dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned month_length(int unsigned mo, int unsigned yr);
      bit leap;
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      case (mo)
         2:                      return leap ? 29 : 28;
         4, 6, 9, 11:            return 30;
         1, 3, 5, 7, 8, 10, 12:  return 31;
         default:                return 0;
      endcase
   endfunction

   // any digit above 9 yields DIGIT_ERROR, which then fails every range check
   function automatic int unsigned bcd_value(logic [15:0] v, int n);
      int unsigned acc;
      acc = 0;
      for (int i = n - 1; i >= 0; i--) begin
         if (v[4*i +: 4] > 4'd9) return DIGIT_ERROR;
         acc = acc * 10 + v[4*i +: 4];
      end
      return acc;
   endfunction

   function automatic logic [15:0] to_bcd(int unsigned v);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = 4'(v % 10);
         v = v / 10;
      end
      return r;
   endfunction

   function automatic logic [7:0] coded8(int unsigned v, bit bcd_op);
      return bcd_op ? 8'(to_bcd(v)) : 8'(v);
   endfunction

   function automatic rdtc_pkg::rsp_type predict_rtc_words(rdtc_pkg::req_type r,
                                                           bit acc, bit bsup);
      rdtc_pkg::rsp_type p;
      int unsigned       yr, mo, dy, hh, mi, ss, cc;
      bit                bad;
      p = '0;
      if (!acc) begin
         p.status = rdtc_pkg::STATUS_ACCESS_DISABLED;
         return p;
      end
      if (r.operation == rdtc_pkg::OP_BCD) begin
         yr = bcd_value(r.year, 4);
         mo = bcd_value(16'(r.month), 2);
         dy = bcd_value(16'(r.day), 2);
         hh = bcd_value(16'(r.hour), 2);
         mi = bcd_value(16'(r.minute), 2);
         ss = bcd_value(16'(r.second), 2);
         cc = bcd_value(16'(r.centisecond), 2);
      end else begin
         yr = 32'(r.year);
         mo = 32'(r.month);
         dy = 32'(r.day);
         hh = 32'(r.hour);
         mi = 32'(r.minute);
         ss = 32'(r.second);
         cc = 32'(r.centisecond);
      end
      bad = (yr < rdtc_pkg::YEAR_MIN) || (yr > rdtc_pkg::YEAR_MAX) ||
            (mo < 1) || (mo > rdtc_pkg::MONTH_MAX) ||
            (dy < 1) || (dy > month_length(mo, yr)) || (hh > rdtc_pkg::HOUR_MAX) ||
            (mi > rdtc_pkg::MINUTE_MAX) || (ss > rdtc_pkg::SECOND_MAX) ||
            (cc > rdtc_pkg::CSEC_MAX);
      if (bad) begin
         p.status = rdtc_pkg::STATUS_INVALID;
         return p;
      end
      if (r.operation == rdtc_pkg::OP_BCD && !bsup) begin
         p.status = rdtc_pkg::STATUS_BCD_UNSUPPORTED;
         return p;
      end
      p.status        = rdtc_pkg::STATUS_OK;
      p.rtc_time_word = {coded8(hh, 1), coded8(mi, 1), coded8(ss, 1), coded8(cc, 1)};
      p.rtc_date_word = {to_bcd(yr), coded8(mo, 1), coded8(dy, 1)};
      return p;
   endfunction

   // mostly well-formed dates, some with one field pushed out, some pure noise
   function automatic rdtc_pkg::req_type make_random_item();
      rdtc_pkg::req_type r;
      logic [95:0]       raw;
      int unsigned       yr, mo, dy, hh, mi, ss, cc, roll;
      field_sel_type     hit;
      bit                bcd_op, raw_hit;
      roll    = $urandom_range(0, 99);
      bcd_op  = 1'($urandom_range(0, 1));
      hit     = field_sel_type'($urandom_range(0, 6));
      raw_hit = 1'($urandom_range(0, 1));
      yr = 2000 + $urandom_range(0, 99);
      mo = $urandom_range(1, 12);
      dy = ($urandom_range(0, 3) == 0) ? month_length(mo, yr)
                                       : $urandom_range(1, month_length(mo, yr));
      hh = ($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23);
      mi = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
      ss = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
      cc = ($urandom_range(0, 7) == 0) ? 99 : $urandom_range(0, 99);
      if (roll >= 70 && !raw_hit) begin
         case (hit)
            F_YEAR:   yr = $urandom_range(0, 1) ? 1999 : 2100;
            F_MONTH:  mo = $urandom_range(0, 1) ? 0 : 13;
            F_DAY:    dy = $urandom_range(0, 1) ? 0 : month_length(mo, yr) + 1;
            F_HOUR:   hh = 24;
            F_MINUTE: mi = 60;
            F_SECOND: ss = 60;
            F_CSEC:   cc = 100;
            default: ;
         endcase
      end
      r.operation   = bcd_op;
      r.year        = bcd_op ? to_bcd(yr) : 16'(yr);
      r.month       = coded8(mo, bcd_op);
      r.day         = coded8(dy, bcd_op);
      r.hour        = coded8(hh, bcd_op);
      r.minute      = coded8(mi, bcd_op);
      r.second      = coded8(ss, bcd_op);
      r.centisecond = coded8(cc, bcd_op);
      if (roll >= 70 && raw_hit) begin
         case (hit)
            F_YEAR:   r.year        = 16'($urandom);
            F_MONTH:  r.month       = 8'($urandom);
            F_DAY:    r.day         = 8'($urandom);
            F_HOUR:   r.hour        = 8'($urandom);
            F_MINUTE: r.minute      = 8'($urandom);
            F_SECOND: r.second      = 8'($urandom);
            F_CSEC:   r.centisecond = 8'($urandom);
            default: ;
         endcase
      end
      if (roll >= 85) begin
         raw = {$urandom, $urandom, $urandom};
         r   = raw[64:0];
      end
      return r;
   endfunction

   task automatic add_row(input bit acc, bsup, input logic op, input logic [15:0] yr,
                          input logic [7:0] mo, dy, hh, mi, ss, cc,
                          input bit typed, input logic [1:0] st, input logic [31:0] tw, dw);
      vector_row_type v;
      v.acc  = acc;
      v.bsup = bsup;
      v.item = '{op, yr, mo, dy, hh, mi, ss, cc};
      v.typed = typed;
      v.exp  = '{st, tw, dw};
      vectors.push_back(v);
   endtask

   task automatic check_field(input string label, input logic [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%h, got 0x%h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   task automatic push_item(input rdtc_pkg::req_type item, input bit typed,
                            input rdtc_pkg::rsp_type exp);
      req_valid     <= 1'b1;
      req_data      <= item;
      req_exp_typed <= typed;
      req_exp_val   <= exp;
      do @(posedge clock); while (!req_ready);
      items_accepted++;
   endtask

   task automatic sender_gap();
      if (!no_idle && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_seen != items_accepted) @(posedge clock);
   endtask

   task automatic write_config(input bit acc, bsup);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= rdtc_pkg::CSR_ACCESS_ENABLE;
      csr_wdata <= acc;
      do @(posedge clock); while (!csr_ready);
      csr_index <= rdtc_pkg::CSR_BCD_PATH_SUPPORTED;
      csr_wdata <= bsup;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_acc  = acc;
      cfg_bsup = bsup;
      @(posedge clock);
   endtask

   // result side: random stall bursts, none in the last phase
   always @(posedge clock) begin
      if (reset || no_idle) begin
         rsp_ready <= 1'b1;
      end else if (rx_hold == 0) begin
         rsp_ready <= ($urandom_range(0, 99) >= 30);
         rx_hold   <= $urandom_range(0, 7);
      end else begin
         rx_hold <= rx_hold - 1;
      end
   end

   always @(posedge clock) begin : result_check
      rdtc_pkg::rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rdtc_pkg::CSR_ACCESS_ENABLE:      mirror_acc  = csr_wdata;
               rdtc_pkg::CSR_BCD_PATH_SUPPORTED: mirror_bsup = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            rtc_words_due.push_back(req_exp_typed ? req_exp_val
                                    : predict_rtc_words(req_data, mirror_acc, mirror_bsup));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rtc_words_due.size() == 0) begin
               $display("%0t: result with nothing expected, got 0x%h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = rtc_words_due.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("rtc_time_word", want.rtc_time_word, rsp_data.rtc_time_word);
               check_field("rtc_date_word", want.rtc_date_word, rsp_data.rtc_date_word);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer in %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      bit acc, bsup;

      // reset settings first, then access off, then BCD path off
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2000, 1, 1, 0, 0, 0, 0,
              1, rdtc_pkg::STATUS_OK, 'h0, 'h2000_0101);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2099, 12, 31, 23, 59, 59, 99,
              1, rdtc_pkg::STATUS_OK, 'h2359_5999, 'h2099_1231);
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h2000, 'h01, 'h01, 'h00, 'h00, 'h00, 'h00,
              1, rdtc_pkg::STATUS_OK, 'h0, 'h2000_0101);
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h2099, 'h12, 'h31, 'h23, 'h59, 'h59, 'h99,
              1, rdtc_pkg::STATUS_OK, 'h2359_5999, 'h2099_1231);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 1999, 12, 31, 23, 59, 59, 99,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2100, 1, 1, 0, 0, 0, 0,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 'hFFFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2050, 0, 15, 1, 2, 3, 4,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2050, 13, 15, 1, 2, 3, 4,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2024, 2, 29, 12, 30, 45, 50,
              0, rdtc_pkg::STATUS_OK, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2023, 2, 29, 12, 30, 45, 50,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h2000, 'h02, 'h29, 'h07, 'h08, 'h09, 'h10,
              0, rdtc_pkg::STATUS_OK, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2001, 4, 31, 6, 7, 8, 9,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2010, 7, 0, 6, 7, 8, 9,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2010, 7, 4, 24, 0, 0, 0,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2010, 7, 4, 0, 60, 60, 100,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      // digits above 9 on the BCD path
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h2015, 'h1A, 'h15, 'h11, 'h22, 'h33, 'h44,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h20A5, 'h06, 'h15, 'h11, 'h22, 'h33, 'h44,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h2015, 'h06, 'h15, 'h11, 'h22, 'h33, 'h9F,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BCD, 'h0000, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 1, rdtc_pkg::OP_BINARY, 2037, 9, 30, 17, 8, 5, 3,
              0, rdtc_pkg::STATUS_OK, 0, 0);
      add_row(0, 1, rdtc_pkg::OP_BINARY, 2000, 1, 1, 0, 0, 0, 0,
              1, rdtc_pkg::STATUS_ACCESS_DISABLED, 0, 0);
      add_row(0, 1, rdtc_pkg::OP_BCD, 'hFFFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF, 'hFF,
              1, rdtc_pkg::STATUS_ACCESS_DISABLED, 0, 0);
      add_row(1, 0, rdtc_pkg::OP_BCD, 'h2068, 'h10, 'h20, 'h08, 'h09, 'h10, 'h11,
              1, rdtc_pkg::STATUS_BCD_UNSUPPORTED, 0, 0);
      // invalid wins over unsupported
      add_row(1, 0, rdtc_pkg::OP_BCD, 'h2068, 'h13, 'h20, 'h08, 'h09, 'h10, 'h11,
              1, rdtc_pkg::STATUS_INVALID, 0, 0);
      add_row(1, 0, rdtc_pkg::OP_BINARY, 2068, 10, 20, 8, 9, 10, 11,
              0, rdtc_pkg::STATUS_OK, 0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[i]) begin
         if (vectors[i].acc != cfg_acc || vectors[i].bsup != cfg_bsup)
            write_config(vectors[i].acc, vectors[i].bsup);
         sender_gap();
         push_item(vectors[i].item, vectors[i].typed, vectors[i].exp);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:             {acc, bsup} = 2'b11;
            1:             {acc, bsup} = 2'b00;
            2:             {acc, bsup} = 2'b10;
            3:             {acc, bsup} = 2'b01;
            PHASE_COUNT-1: {acc, bsup} = 2'b11;
            default: begin
               // access off only now and then, so most items get checked deeply
               acc  = ($urandom_range(0, 5) != 0);
               bsup = 1'($urandom_range(0, 1));
            end
         endcase
         write_config(acc, bsup);
         no_idle = (phase == PHASE_COUNT - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2)
               wait_drained();
            sender_gap();
            push_item(make_random_item(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (rtc_words_due.size() != 0)
         $display("%0t: %0d results never arrived", $time, rtc_words_due.size());
      if (mismatch_count == 0 && rtc_words_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
